[sv/stereo_volume_peak_limiter_unit_macros.svh]
// Assertion macros for the stereo volume peak limiter
`ifndef STEREO_VOLUME_PEAK_LIMITER_UNIT_MACROS_SVH
`define STEREO_VOLUME_PEAK_LIMITER_UNIT_MACROS_SVH
// implication checked every clock, off in reset
`define SVPL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen at a clock, off in reset
`define SVPL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

[sv/svpl_pkg.sv]
// Shared types and constants for the stereo volume peak limiter
package svpl_pkg;
    localparam int FramesPerBlockDefault = 48;
    localparam logic [14:0] VolumeCap = 15'd25600;
    localparam logic [16:0] Unity = 17'd32768;
    localparam logic [16:0] GainFloor = 17'd256;
    localparam logic [30:0] Threshold = 31'd1610612733;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic signed [31:0] l;
        logic signed [31:0] r;
        logic               last;
        logic [7:0]         lmin;
        logic [7:0]         lmax;
    } svpl_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_PEAK, ST_DIV, ST_GAIN, ST_APPLY, ST_DONE
    } svpl_state_t;

    function automatic logic [7:0] level_byte(input logic signed [31:0] x);
        logic signed [17:0] t;
        begin
            t = 18'(signed'(x[31:16])) + 18'sd32896;
            level_byte = t[15:8];
        end
    endfunction
endpackage

[sv/svpl_front.sv]
// Front end: volume ramp, block levels, frame counting
module svpl_front
    import svpl_pkg::*;
#(
    parameter int FRAMES_PER_BLOCK = FramesPerBlockDefault
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         master_volume,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] left_sample,
    input  logic signed [31:0] right_sample,
    input  logic               q_ready,
    output logic               q_valid,
    output svpl_item_t         q_item,
    output logic [8:0]         q_vol
);
    localparam int IW = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;
    logic [IW-1:0] idx_reg, idx_next;
    logic [14:0] cur_reg, cur_next;
    logic [8:0] vol_reg, vol_next;
    logic signed [31:0] mn_reg, mn_next, mx_reg, mx_next, mn0, mx0;
    logic [14:0] tgt;
    logic signed [16:0] d;
    logic first, last, acc;

    assign in_ready = q_ready;
    assign q_valid = in_valid;
    assign acc = in_valid && q_ready;
    assign first = (idx_reg == '0);
    assign last = (idx_reg == IW'(FRAMES_PER_BLOCK - 1));

    always_comb
    begin
        tgt = (master_volume > 8'd100) ? VolumeCap : {master_volume[6:0], 8'd0};
        d = 17'(signed'({2'b0, tgt})) - 17'(signed'({2'b0, cur_reg}))
            + ((tgt < cur_reg) ? 17'sd0 : 17'sd32);
        cur_next = cur_reg;
        vol_next = vol_reg;
        if (first && (cur_reg != tgt))
        begin
            cur_next = 15'(17'(signed'({2'b0, cur_reg})) + (d >>> 5));
            vol_next = 9'((32'(cur_next) * 32'd41944) >> 22);
        end
        mn0 = first ? 32'sh7fffffff : mn_reg;
        mx0 = first ? 32'sh80000000 : mx_reg;
        mn_next = mn0;
        mx_next = mx0;
        if (left_sample < mn_next) mn_next = left_sample;
        if (right_sample < mn_next) mn_next = right_sample;
        if (left_sample > mx_next) mx_next = left_sample;
        if (right_sample > mx_next) mx_next = right_sample;
        idx_next = last ? '0 : idx_reg + 1'b1;
        q_item.l = left_sample;
        q_item.r = right_sample;
        q_item.last = last;
        q_item.lmin = last ? level_byte(mn_next) : 8'd0;
        q_item.lmax = last ? level_byte(mx_next) : 8'd0;
        q_vol = vol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cur_reg <= '0;
            vol_reg <= '0;
            mn_reg <= 32'sh7fffffff;
            mx_reg <= 32'sh80000000;
        end
        else if (acc)
        begin
            idx_reg <= idx_next;
            cur_reg <= cur_next;
            vol_reg <= vol_next;
            mn_reg <= mn_next;
            mx_reg <= mx_next;
        end
    end
endmodule

[sv/svpl_queue.sv]
// Two-entry item queue between front and back
module svpl_queue
    import svpl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  svpl_item_t wr_item,
    input  logic [8:0] wr_vol,
    output logic       rd_valid,
    input  logic       rd_ready,
    output svpl_item_t rd_item,
    output logic [8:0] rd_vol
);
    svpl_item_t it_reg [QueueDepth];
    logic [8:0] vl_reg [QueueDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != 2'(QueueDepth));
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_item = it_reg[rp_reg];
    assign rd_vol = vl_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            it_reg[wp_reg] <= wr_item;
            vl_reg[wp_reg] <= wr_vol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

[sv/svpl_back.sv]
// Back end: gain multiply, peak limiter with serial divider, saturation
module svpl_back
    import svpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  svpl_item_t         q_item,
    input  logic [8:0]         q_vol,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_left,
    output logic signed [31:0] out_right,
    output logic               block_end,
    output logic [7:0]         level_min,
    output logic [7:0]         level_max
);
    localparam logic [45:0] Dividend = {Threshold, 15'd0};

    svpl_state_t st_reg, st_next;
    svpl_item_t it_reg;
    logic [8:0] vol_reg;
    logic signed [41:0] a_reg, b_reg;
    logic [16:0] g_reg, g_next;
    logic [40:0] pk_reg;
    logic [46:0] rem_reg;
    logic [16:0] quo_reg;
    logic [5:0] cnt_reg;
    logic ov_reg;
    logic signed [41:0] pa, pk_l, pk_r;
    logic [57:0] prot;
    logic [47:0] trial;
    logic dbit;
    logic signed [59:0] ml, mr;
    logic [16:0] diff;

    assign q_ready = (st_reg == ST_IDLE);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (q_valid) st_next = ST_MUL1;
            ST_MUL1:  st_next = ST_MUL2;
            ST_MUL2:  st_next = ST_PEAK;
            ST_PEAK:  st_next = ov_reg ? ST_DIV : ST_GAIN;
            ST_DIV:   if (cnt_reg == 6'd0) st_next = ST_GAIN;
            ST_GAIN:  st_next = ST_APPLY;
            ST_APPLY: st_next = ST_DONE;
            ST_DONE:  if (!out_valid || out_ready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pk_l = (a_reg < 0) ? -a_reg : a_reg;
        pk_r = (b_reg < 0) ? -b_reg : b_reg;
        pa = (pk_l > pk_r) ? pk_l : pk_r;
        prot = (g_reg == Unity) ? {17'd0, pa[40:0]} : (58'(pa[40:0]) * 58'(g_reg)) >> 15;
        dbit = Dividend[cnt_reg];
        trial = {rem_reg, dbit} - {7'd0, pk_reg};
        diff = Unity - g_reg;
        g_next = g_reg;
        if (ov_reg)
        begin
            if ((quo_reg < GainFloor ? GainFloor : quo_reg) < g_reg)
                g_next = (quo_reg < GainFloor) ? GainFloor : quo_reg;
        end
        else if (g_reg < Unity)
            g_next = g_reg + ((diff > 17'd1024) ? (diff >> 10) : 17'd1);
        ml = 60'(a_reg) * 60'(signed'({1'b0, g_reg}));
        mr = 60'(b_reg) * 60'(signed'({1'b0, g_reg}));
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                it_reg <= q_item;
                vol_reg <= q_vol;
            end
            ST_MUL1:
            begin
                a_reg <= 42'(signed'(it_reg.l >>> 8)) * 42'(signed'({1'b0, vol_reg}));
                b_reg <= 42'(signed'(it_reg.r >>> 8)) * 42'(signed'({1'b0, vol_reg}));
            end
            ST_MUL2:
            begin
                a_reg <= (a_reg * 42'sd448) >>> 8;
                b_reg <= (b_reg * 42'sd448) >>> 8;
            end
            ST_PEAK:
            begin
                ov_reg <= prot > 58'(Threshold);
                pk_reg <= pa[40:0];
                rem_reg <= 47'd0;
                quo_reg <= 17'd0;
                cnt_reg <= 6'd45;
            end
            ST_DIV:
            begin
                if (!trial[47])
                    rem_reg <= trial[46:0];
                else
                    rem_reg <= {rem_reg[45:0], dbit};
                quo_reg <= (quo_reg << 1) | 17'(!trial[47]);
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_APPLY:
            begin
                if (g_reg < Unity)
                begin
                    a_reg <= 42'(ml >>> 15);
                    b_reg <= 42'(mr >>> 15);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            g_reg <= Unity;
            out_valid <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_GAIN) g_reg <= g_next;
            if (st_reg == ST_DONE && (!out_valid || out_ready))
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_DONE && (!out_valid || out_ready))
        begin
            out_left <= (a_reg > 42'sh7fffffff) ? 32'sh7fffffff
                        : (a_reg < -42'sh80000000) ? 32'sh80000000 : a_reg[31:0];
            out_right <= (b_reg > 42'sh7fffffff) ? 32'sh7fffffff
                         : (b_reg < -42'sh80000000) ? 32'sh80000000 : b_reg[31:0];
            block_end <= it_reg.last;
            level_min <= it_reg.lmin;
            level_max <= it_reg.lmax;
        end
    end
endmodule

[sv/stereo_volume_peak_limiter_unit.sv]
// Top level of the stereo volume peak limiter
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes master_volume; always ready.
//   in channel takes one stereo frame (left_sample, right_sample) per item.
//   out channel gives one processed frame per item, with block_end and the
//   block level bytes on the last frame of each block.
// A frame with no limiting skips the attack divider; the back end's 46-step
//   restoring divider sets the worst case, and the back end takes a new item
//   only once the last one has left its done state.
// The front end and a two-entry queue keep taking frames while the back
//   end computes, so input waits only when the queue is full.
// Reset clears the volume ramp, limiter gain (unity), frame counter and
//   queue; no clearing pass is needed.
// A stalled receiver holds the result register; the back end waits in its
//   done state and the queue fills, then in_ready drops.
module stereo_volume_peak_limiter_unit
    import svpl_pkg::*;
#(
    parameter int FRAMES_PER_BLOCK = FramesPerBlockDefault
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] left_sample,
    input  logic signed [31:0] right_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_left,
    output logic signed [31:0] out_right,
    output logic               block_end,
    output logic [7:0]         level_min,
    output logic [7:0]         level_max
);
    logic [7:0] mv_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    svpl_item_t fq_item, qb_item;
    logic [8:0] fq_vol, qb_vol;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 8'd0;
        else if (cfg_valid)
            mv_reg <= cfg_data;
    end

    svpl_front #(.FRAMES_PER_BLOCK(FRAMES_PER_BLOCK)) u_front (
        .clk, .rst_n, .master_volume(mv_reg), .in_valid, .in_ready,
        .left_sample, .right_sample, .q_ready(fq_ready), .q_valid(fq_valid),
        .q_item(fq_item), .q_vol(fq_vol)
    );

    svpl_queue u_queue (
        .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
        .wr_vol(fq_vol), .rd_valid(qb_valid), .rd_ready(qb_ready),
        .rd_item(qb_item), .rd_vol(qb_vol)
    );

    svpl_back u_back (
        .clk, .rst_n, .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
        .q_vol(qb_vol), .out_valid, .out_ready, .out_left, .out_right,
        .block_end, .level_min, .level_max
    );
endmodule

[sv/svpl_checker.sv]
// Port checker for the stereo volume peak limiter
`include "stereo_volume_peak_limiter_unit_macros.svh"
module svpl_props (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        block_end,
    input logic [7:0]  level_min,
    input logic [7:0]  level_max,
    input logic [31:0] out_left
);
    `SVPL_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_left), "item lost")
    `SVPL_ASSERT(a_lvl_min, clk, rst_n, out_valid && !block_end |-> level_min == 8'd0, "level_min set")
    `SVPL_ASSERT_NEVER(a_lvl_max, clk, rst_n, out_valid && !block_end && level_max != 8'd0, "level_max set")
endmodule

bind stereo_volume_peak_limiter_unit svpl_props u_chk (
    .clk, .rst_n, .out_valid, .out_ready, .block_end, .level_min, .level_max, .out_left
);
